>>> rtl/ilb_pkg.sv
// Shared types and codes for the indexed list buffer.
`timescale 1ns / 1ps
`default_nettype none

package ilb_pkg;

	localparam int OP_W     = 4;
	localparam int IDX_W    = 7;
	localparam int WORD_W   = 64;
	localparam int STATUS_W = 2;
	localparam int LEN_W    = 7;

	localparam logic [OP_W-1:0] OP_APPEND     = 4'd0;
	localparam logic [OP_W-1:0] OP_REMOVE     = 4'd1;
	localparam logic [OP_W-1:0] OP_INSERT     = 4'd2;
	localparam logic [OP_W-1:0] OP_ERASE      = 4'd3;
	localparam logic [OP_W-1:0] OP_READ_INDEX = 4'd4;
	localparam logic [OP_W-1:0] OP_READ_FIRST = 4'd5;
	localparam logic [OP_W-1:0] OP_READ_LAST  = 4'd6;
	localparam logic [OP_W-1:0] OP_CLEAR      = 4'd7;
	localparam logic [OP_W-1:0] OP_RESIZE     = 4'd8;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic [IDX_W-1:0]  index;
		logic [OP_W-1:0]   op;
	} req_t;

	typedef struct packed {
		logic [LEN_W-1:0]    length;
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   data;
	} result_t;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_EXEC  = 8'b0000_0010,
		S_SHIFT = 8'b0000_0100,
		S_DRAIN = 8'b0000_1000,
		S_PUT   = 8'b0001_0000,
		S_FILL  = 8'b0010_0000,
		S_READ  = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

endpackage

`default_nettype wire

>>> rtl/ilb_mem.sv
// Element storage: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ilb_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [AW-1:0]              waddr,
	input  wire logic [ilb_pkg::WORD_W-1:0] wdata,
	input  wire logic [AW-1:0]              raddr,
	output logic      [ilb_pkg::WORD_W-1:0] rdata
);

	logic [ilb_pkg::WORD_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/ilb_seq.sv
// Sequencer: decodes a request, steps the shared address pointer and keeps the length.
`timescale 1ns / 1ps
`default_nettype none

module ilb_seq #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire ilb_pkg::req_t              req,
	output logic                            idle,
	input  wire logic                       out_free,
	output logic                            res_valid,
	output ilb_pkg::result_t                res,
	output logic                            mem_we,
	output logic      [AW-1:0]              mem_waddr,
	output logic      [ilb_pkg::WORD_W-1:0] mem_wdata,
	output logic      [AW-1:0]              mem_raddr,
	input  wire logic [ilb_pkg::WORD_W-1:0] mem_rdata
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > ilb_pkg::IDX_W) ? CW : ilb_pkg::IDX_W;

	ilb_pkg::state_t                state_q;
	logic [ilb_pkg::OP_W-1:0]       op_q;
	logic [ilb_pkg::IDX_W-1:0]      idx_q;
	logic [ilb_pkg::WORD_W-1:0]     val_q;
	logic [CW-1:0]                  count_q;
	logic [AW-1:0]                  ptr_q;
	logic [AW-1:0]                  dst_q;
	logic                           first_q;
	logic [ilb_pkg::STATUS_W-1:0]   status_q;
	logic [ilb_pkg::WORD_W-1:0]     data_q;

	logic [CMPW-1:0] idx_ext;
	logic [CMPW-1:0] idx_p1;
	logic [CMPW-1:0] cnt_ext;
	logic [CMPW-1:0] cnt_m1;
	logic [CMPW-1:0] ptr_p1_ext;
	logic [CMPW-1:0] depth_ext;
	logic            full;
	logic            empty;
	logic            shift_up;
	logic            shift_last;
	logic [AW-1:0]   rd_addr;

	assign idx_ext    = CMPW'(idx_q);
	assign idx_p1     = idx_ext + 1'b1;
	assign cnt_ext    = CMPW'(count_q);
	assign cnt_m1     = cnt_ext - 1'b1;
	assign ptr_p1_ext = CMPW'(ptr_q) + 1'b1;
	assign depth_ext  = CMPW'(DEPTH);
	assign full       = (cnt_ext == depth_ext);
	assign empty      = (count_q == '0);
	assign shift_up   = (op_q == ilb_pkg::OP_INSERT);
	assign shift_last = shift_up ? (ptr_q == idx_ext[AW-1:0]) : (ptr_q == cnt_m1[AW-1:0]);

	always_comb begin
		priority if (op_q == ilb_pkg::OP_READ_INDEX) begin
			rd_addr = idx_ext[AW-1:0];
		end else if (op_q == ilb_pkg::OP_READ_LAST) begin
			rd_addr = cnt_m1[AW-1:0];
		end else begin
			rd_addr = '0;
		end
	end

	// Memory port: shift writes the word read in the previous cycle while reading the next.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = val_q;
		mem_raddr = ptr_q;
		unique case (state_q)
			ilb_pkg::S_EXEC: begin
				mem_raddr = rd_addr;
			end
			ilb_pkg::S_SHIFT: begin
				mem_we    = !first_q;
				mem_waddr = dst_q;
				mem_wdata = mem_rdata;
			end
			ilb_pkg::S_DRAIN: begin
				mem_we    = 1'b1;
				mem_waddr = dst_q;
				mem_wdata = mem_rdata;
			end
			ilb_pkg::S_PUT, ilb_pkg::S_FILL: begin
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign idle       = (state_q == ilb_pkg::S_IDLE);
	assign res_valid  = (state_q == ilb_pkg::S_DONE);
	assign res.data   = data_q;
	assign res.status = status_q;
	assign res.length = cnt_ext[ilb_pkg::LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ilb_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ilb_pkg::S_IDLE: begin
					if (start) begin
						state_q <= ilb_pkg::S_EXEC;
					end
				end
				ilb_pkg::S_EXEC: begin
					state_q <= ilb_pkg::S_DONE;
					unique case (op_q)
						ilb_pkg::OP_APPEND: begin
							if (!full) begin
								state_q <= ilb_pkg::S_PUT;
							end
						end
						ilb_pkg::OP_REMOVE: begin
							if (!empty) begin
								count_q <= count_q - 1'b1;
							end
						end
						ilb_pkg::OP_INSERT: begin
							if (idx_ext <= cnt_ext && !full) begin
								state_q <= (idx_ext == cnt_ext) ? ilb_pkg::S_PUT
									: ilb_pkg::S_SHIFT;
							end
						end
						ilb_pkg::OP_ERASE: begin
							if (idx_ext < cnt_ext) begin
								if (idx_p1 == cnt_ext) begin
									count_q <= count_q - 1'b1;
								end else begin
									state_q <= ilb_pkg::S_SHIFT;
								end
							end
						end
						ilb_pkg::OP_READ_INDEX: begin
							if (idx_ext < cnt_ext) begin
								state_q <= ilb_pkg::S_READ;
							end
						end
						ilb_pkg::OP_READ_FIRST, ilb_pkg::OP_READ_LAST: begin
							if (!empty) begin
								state_q <= ilb_pkg::S_READ;
							end
						end
						ilb_pkg::OP_CLEAR: begin
							count_q <= '0;
						end
						ilb_pkg::OP_RESIZE: begin
							if (idx_ext <= depth_ext) begin
								if (idx_ext > cnt_ext) begin
									state_q <= ilb_pkg::S_FILL;
								end else begin
									count_q <= idx_ext[CW-1:0];
								end
							end
						end
						default: begin
						end
					endcase
				end
				ilb_pkg::S_SHIFT: begin
					if (shift_last) begin
						state_q <= ilb_pkg::S_DRAIN;
					end
				end
				ilb_pkg::S_DRAIN: begin
					if (shift_up) begin
						state_q <= ilb_pkg::S_PUT;
					end else begin
						count_q <= count_q - 1'b1;
						state_q <= ilb_pkg::S_DONE;
					end
				end
				ilb_pkg::S_PUT: begin
					count_q <= count_q + 1'b1;
					state_q <= ilb_pkg::S_DONE;
				end
				ilb_pkg::S_FILL: begin
					if (ptr_p1_ext == idx_ext) begin
						count_q <= idx_ext[CW-1:0];
						state_q <= ilb_pkg::S_DONE;
					end
				end
				ilb_pkg::S_READ: begin
					state_q <= ilb_pkg::S_DONE;
				end
				ilb_pkg::S_DONE: begin
					if (out_free) begin
						state_q <= ilb_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= ilb_pkg::S_IDLE;
				end
			endcase
		end
	end

	// Payload side: request copy, pointer stepping and result word.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ilb_pkg::S_IDLE: begin
				if (start) begin
					op_q  <= req.op;
					idx_q <= req.index;
					val_q <= req.value;
				end
			end
			ilb_pkg::S_EXEC: begin
				data_q   <= '0;
				status_q <= ilb_pkg::ST_OK;
				first_q  <= 1'b1;
				unique case (op_q)
					ilb_pkg::OP_APPEND: begin
						ptr_q <= cnt_ext[AW-1:0];
						if (full) begin
							status_q <= ilb_pkg::ST_FULL;
						end
					end
					ilb_pkg::OP_REMOVE, ilb_pkg::OP_READ_FIRST,
					ilb_pkg::OP_READ_LAST: begin
						if (empty) begin
							status_q <= ilb_pkg::ST_RANGE;
						end
					end
					ilb_pkg::OP_INSERT: begin
						if (idx_ext > cnt_ext) begin
							status_q <= ilb_pkg::ST_RANGE;
						end else if (full) begin
							status_q <= ilb_pkg::ST_FULL;
						end
						ptr_q <= (idx_ext == cnt_ext) ? idx_ext[AW-1:0] : cnt_m1[AW-1:0];
					end
					ilb_pkg::OP_ERASE, ilb_pkg::OP_READ_INDEX: begin
						if (idx_ext >= cnt_ext) begin
							status_q <= ilb_pkg::ST_RANGE;
						end
						ptr_q <= idx_p1[AW-1:0];
					end
					ilb_pkg::OP_CLEAR: begin
					end
					ilb_pkg::OP_RESIZE: begin
						if (idx_ext > depth_ext) begin
							status_q <= ilb_pkg::ST_FULL;
						end
						ptr_q <= cnt_ext[AW-1:0];
					end
					default: begin
						status_q <= ilb_pkg::ST_RANGE;
					end
				endcase
			end
			ilb_pkg::S_SHIFT: begin
				first_q <= 1'b0;
				dst_q   <= shift_up ? (ptr_q + 1'b1) : (ptr_q - 1'b1);
				if (!shift_last) begin
					ptr_q <= shift_up ? (ptr_q - 1'b1) : (ptr_q + 1'b1);
				end
			end
			ilb_pkg::S_DRAIN: begin
				// Insert ends by writing the new word at its index.
				ptr_q <= idx_ext[AW-1:0];
			end
			ilb_pkg::S_FILL: begin
				ptr_q <= ptr_q + 1'b1;
			end
			ilb_pkg::S_READ: begin
				data_q <= mem_rdata;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/indexed_list_buffer.sv
// Top level of the indexed list buffer: stream ports, storage and result register.
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to DEPTH 64-bit words with append, remove last, insert, erase,
// indexed and end reads, clear and resize. Each request word yields exactly one result
// word carrying the data read, a status and the new length. One request is worked on at
// a time. Remove last, clear, a resize that does not grow, erase of the last entry and
// every rejected request finish in the execute state; append and insert at the end add
// a put state, and the three reads a read state. Insert at i below the length and erase
// at i below count - 1 move the entries behind i through the shift and drain states,
// one entry per cycle on the single memory write port, before insert puts the new word;
// a growing resize fills the new entries through the fill state at the same rate. A
// finished result moves into the output register, so the next request can be taken
// before it is collected; a result that finishes while that register still holds an
// uncollected word waits, and the block stays busy until the sink takes the older word.

module indexed_list_buffer #(
	parameter int DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,  // op [3:0], index [10:4], value [74:11], zero [79:75]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [79:0] m_tdata   // data [63:0], status [65:64], length [72:66], zero [79:73]
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	ilb_pkg::req_t              req;
	ilb_pkg::result_t           res;
	ilb_pkg::result_t           out_q;
	logic                       out_valid_q;
	logic                       out_free;
	logic                       seq_idle;
	logic                       res_valid;
	logic                       mem_we;
	logic [AW-1:0]              mem_waddr;
	logic [ilb_pkg::WORD_W-1:0] mem_wdata;
	logic [AW-1:0]              mem_raddr;
	logic [ilb_pkg::WORD_W-1:0] mem_rdata;

	assign req.op    = s_tdata[3:0];
	assign req.index = s_tdata[10:4];
	assign req.value = s_tdata[74:11];

	assign s_tready = seq_idle;
	assign out_free = !out_valid_q || m_tready;

	ilb_seq #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_tvalid && s_tready),
		.req       (req),
		.idle      (seq_idle),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	ilb_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Hold the result word until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_free) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q};

endmodule

`default_nettype wire
